>>> rtl/lom_pkg.sv
// ----------------------------------------------------------------------------
// lom_pkg: shared types and constants for the limit order matcher
// Field widths, request and status codes, and the book entry layout.
// ----------------------------------------------------------------------------
package lom_pkg;

  localparam int unsigned ORDERS_PER_SIDE_DEF = 32;
  localparam int unsigned MAX_FILLS           = 32;

  localparam int unsigned ID_W    = 32;
  localparam int unsigned PRICE_W = 16;
  localparam int unsigned QTY_W   = 20;
  localparam int unsigned ARR_W   = 32;
  localparam int unsigned STAT_W  = 2;

  // request codes
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_MATCH = 1'b1;

  // side codes
  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_ZERO_QTY = 2'd2;

  // one resting order as stored in the book memory
  typedef struct packed {
    logic [ARR_W-1:0]   arrival;
    logic [ID_W-1:0]    id;
    logic [QTY_W-1:0]   qty;
    logic [PRICE_W-1:0] price;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // one result beat before packing
  typedef struct packed {
    logic               last;
    logic [STAT_W-1:0]  status;
    logic [QTY_W-1:0]   remaining_qty;
    logic [QTY_W-1:0]   fill_qty;
    logic [PRICE_W-1:0] fill_price;
    logic [ID_W-1:0]    sell_order_id;
    logic [ID_W-1:0]    buy_order_id;
    logic               trade_valid;
  } result_t;

endpackage

>>> rtl/lom_ram.sv
// ----------------------------------------------------------------------------
// lom_ram: generic single-port-write, single-port-read RAM
// Registered read data, returned in the cycle after the read address.
// ----------------------------------------------------------------------------
module lom_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/limit_order_matcher.sv
// ----------------------------------------------------------------------------
// limit_order_matcher: price-time priority order matching engine
// Book entries in one RAM, valid bits in flops, a sequencer scans one slot
// per cycle for the best entry or a free slot, writes the fill or new order.
// ----------------------------------------------------------------------------
// Add: one scan of its own side for a free slot, then one status beat.
// Match: one scan of the opposite side per fill, read slot by slot through the
// single read port of the book RAM, then one result beat per fill.
// A fill beat is held until it is known whether another fill follows.
// One request is in work at a time; output stalls hold the sequencer.
// Reset: valid bits and arrival counter cleared at once, no clearing pass.
module limit_order_matcher #(
  parameter int unsigned ORDERS_PER_SIDE = lom_pkg::ORDERS_PER_SIDE_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata, low bit up: order_id[31:0], price[47:32], quantity[67:48], zero pad
  input  logic [71:0]  s_tdata,
  // tuser, low bit up: req_type[0], side[1]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata, low bit up: buy_order_id[31:0], sell_order_id[63:32],
  // fill_price[79:64], fill_qty[99:80], remaining_qty[119:100]
  output logic [119:0] m_tdata,
  // tuser, low bit up: trade_valid[0], status[2:1]
  output logic [2:0]   m_tuser,
  output logic         m_tlast
);

  localparam int unsigned SLOTS  = 2 * ORDERS_PER_SIDE;
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned IDX_W  = $clog2(ORDERS_PER_SIDE + 1);
  localparam int unsigned CNT_W  = $clog2(lom_pkg::MAX_FILLS + 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_WAIT, S_APPLY, S_OUT} state_t;

  state_t state;
  logic [SLOTS-1:0] valid;
  logic [lom_pkg::ARR_W-1:0] arrival_counter;

  // request registers
  logic                        req_type, side;
  logic [lom_pkg::ID_W-1:0]    req_id;
  logic [lom_pkg::PRICE_W-1:0] req_price;
  logic [lom_pkg::QTY_W-1:0]   remaining;
  logic [CNT_W-1:0]            fill_count;

  // scan state
  logic [IDX_W-1:0]   idx;
  logic               rd_pend;
  logic [SLOT_W-1:0]  rd_slot;
  logic               best_found;
  logic [SLOT_W-1:0]  best_slot;
  lom_pkg::entry_t    best;
  logic               free_found;
  logic [SLOT_W-1:0]  free_slot;

  // RAM ports
  logic               we;
  logic [SLOT_W-1:0]  waddr, raddr;
  lom_pkg::entry_t    wdata, rdata;

  lom_pkg::result_t res;
  logic             out_full;

  // fill beat waiting for its last flag
  lom_pkg::result_t held, held_last;

  lom_ram #(.WIDTH(lom_pkg::ENTRY_W), .DEPTH(SLOTS)) u_book (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // base slot of the side being scanned
  logic             scan_side;
  logic [SLOT_W-1:0] scan_base;
  assign scan_side = (req_type == lom_pkg::REQ_ADD) ? side : ~side;
  assign scan_base = scan_side ? SLOT_W'(ORDERS_PER_SIDE) : '0;
  assign raddr     = scan_base + SLOT_W'(idx);

  // compare the returned entry against the current best
  logic                      cand_better;
  logic [lom_pkg::ARR_W-1:0] age_c, age_b;
  always_comb begin
    age_c = arrival_counter - rdata.arrival;
    age_b = arrival_counter - best.arrival;
    if (!best_found) begin
      cand_better = 1'b1;
    end else if (rdata.price != best.price) begin
      cand_better = scan_side ? (rdata.price < best.price) : (rdata.price > best.price);
    end else begin
      cand_better = age_c > age_b;
    end
  end

  // fill computation on the chosen entry
  logic                      crosses;
  logic [lom_pkg::QTY_W-1:0] fill;
  assign crosses = (side == lom_pkg::SIDE_BUY) ? (req_price >= best.price)
                                               : (req_price <= best.price);
  assign fill = (remaining < best.qty) ? remaining : best.qty;

  // held fill closing the request
  always_comb begin
    held_last      = held;
    held_last.last = 1'b1;
  end

  assign s_tready = (state == S_IDLE) && !out_full;
  assign m_tvalid = out_full;
  assign m_tdata  = {res.remaining_qty, res.fill_qty, res.fill_price,
                     res.sell_order_id, res.buy_order_id};
  assign m_tuser  = {res.status, res.trade_valid};
  assign m_tlast  = res.last;

  // write port: add stores the new entry, apply writes back the reduced qty
  always_comb begin
    we    = 1'b0;
    waddr = best_slot;
    wdata = best;
    if (state == S_APPLY && !out_full) begin
      if (req_type == lom_pkg::REQ_ADD) begin
        we    = (remaining != '0) && free_found;
        waddr = free_slot;
        wdata = '{arrival: arrival_counter, id: req_id, qty: remaining,
                  price: req_price};
      end else if (best_found && crosses && remaining != '0
                   && fill_count < CNT_W'(lom_pkg::MAX_FILLS)) begin
        we        = 1'b1;
        wdata.qty = best.qty - fill;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      valid           <= '0;
      arrival_counter <= '0;
      out_full        <= 1'b0;
      rd_pend         <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        out_full <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            req_type   <= s_tuser[0];
            side       <= s_tuser[1];
            req_id     <= s_tdata[31:0];
            req_price  <= s_tdata[47:32];
            remaining  <= s_tdata[67:48];
            fill_count <= '0;
            idx        <= '0;
            best_found <= 1'b0;
            free_found <= 1'b0;
            rd_pend    <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue one read per cycle, evaluate the one returned
          rd_pend <= (idx < IDX_W'(ORDERS_PER_SIDE));
          rd_slot <= raddr;
          if (idx < IDX_W'(ORDERS_PER_SIDE)) begin
            idx <= idx + 1'b1;
          end else begin
            state <= S_WAIT;
          end
          if (rd_pend) begin
            if (valid[rd_slot] && cand_better) begin
              best_found <= 1'b1;
              best_slot  <= rd_slot;
              best       <= rdata;
            end
            if (!valid[rd_slot] && !free_found) begin
              free_found <= 1'b1;
              free_slot  <= rd_slot;
            end
          end
        end
        S_WAIT: begin
          rd_pend <= 1'b0;
          if (rd_pend) begin
            if (valid[rd_slot] && cand_better) begin
              best_found <= 1'b1;
              best_slot  <= rd_slot;
              best       <= rdata;
            end
            if (!valid[rd_slot] && !free_found) begin
              free_found <= 1'b1;
              free_slot  <= rd_slot;
            end
          end
          state <= S_APPLY;
        end
        S_APPLY: begin
          // the output register must be free before the next beat is built
          if (!out_full) begin
            if (req_type == lom_pkg::REQ_ADD) begin
              if (remaining == '0) begin
                res <= '{status: lom_pkg::ST_ZERO_QTY, last: 1'b1, default: '0};
              end else if (!free_found) begin
                res <= '{status: lom_pkg::ST_FULL, last: 1'b1, default: '0};
              end else begin
                res              <= '{status: lom_pkg::ST_OK, last: 1'b1, default: '0};
                valid[free_slot] <= 1'b1;
                arrival_counter  <= arrival_counter + 1'b1;
              end
              state <= S_OUT;
            end else if (we) begin
              remaining  <= remaining - fill;
              fill_count <= fill_count + 1'b1;
              if (best.qty == fill) begin
                valid[best_slot] <= 1'b0;
              end
              held <= '{trade_valid:   1'b1,
                        buy_order_id:  side ? best.id : req_id,
                        sell_order_id: side ? req_id : best.id,
                        fill_price:    best.price,
                        fill_qty:      fill,
                        remaining_qty: remaining - fill,
                        status:        lom_pkg::ST_OK,
                        last:          1'b0};
              if (fill_count != '0) begin
                // the previous fill has a successor, so it is not the last
                res   <= held;
                state <= S_OUT;
              end else if ((remaining == fill)
                           || (fill_count + 1'b1 == CNT_W'(lom_pkg::MAX_FILLS))) begin
                state <= S_APPLY;
              end else begin
                idx        <= '0;
                best_found <= 1'b0;
                rd_pend    <= 1'b0;
                state      <= S_SCAN;
              end
            end else if (fill_count == '0) begin
              res   <= '{remaining_qty: remaining, status: lom_pkg::ST_OK, last: 1'b1,
                         default: '0};
              state <= S_OUT;
            end else begin
              // nothing more fills: the held fill closes the request
              res   <= held_last;
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!out_full) begin
            out_full <= 1'b1;
            if (res.last) begin
              state <= S_IDLE;
            end else if (remaining == '0
                         || fill_count == CNT_W'(lom_pkg::MAX_FILLS)) begin
              state <= S_APPLY;
            end else begin
              idx        <= '0;
              best_found <= 1'b0;
              rd_pend    <= 1'b0;
              state      <= S_SCAN;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
